FILE: sv/bis_pkg.sv
// ---------------------------------------------------------------------------
// bis_pkg: shared types and constants for the bilinear image scaler
// Sizes of the frame store, fixed-point format, lane widths and the
// configuration register map.
// ---------------------------------------------------------------------------
package bis_pkg;

    // Frame store geometry (powers of two, address = col * MAX_HEIGHT + row)
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COL_W + ROW_W;

    // Fixed-point format of the steps and weights
    localparam int FRAC_BITS  = 16;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int RGB_W      = 3 * PIX_W;
    localparam int COORD_W    = 12;
    localparam int SIZE_W     = 9;
    localparam int STEP_W     = 24;

    // Interpolation lanes: one per color channel
    localparam int LANES      = 3;
    localparam int LANE_A_W   = PIX_W + FRAC_BITS;
    localparam int LANE_D_W   = ((LANE_A_W > STEP_W) ? LANE_A_W : STEP_W) + 1;
    localparam int LANE_F_W   = (FRAC_BITS > COORD_W) ? FRAC_BITS : COORD_W;
    localparam int LANE_P_W   = LANE_D_W + LANE_F_W + 1;
    localparam int LANE_O_W   = ((PIX_W + 2 * FRAC_BITS) > (STEP_W + COORD_W)) ?
                                (PIX_W + 2 * FRAC_BITS) : (STEP_W + COORD_W);
    localparam int IX_W       = LANE_O_W - FRAC_BITS;

    // APB register map
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 4;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_X_STEP     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_Y_STEP     = 2'd3;

    // Reset values
    localparam logic [SIZE_W-1:0] RST_SRC_WIDTH  = SIZE_W'(256);
    localparam logic [SIZE_W-1:0] RST_SRC_HEIGHT = SIZE_W'(256);
    localparam logic [STEP_W-1:0] RST_STEP       = STEP_W'(65536);

    // Request opcodes
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [SIZE_W-1:0] src_width;
        logic [SIZE_W-1:0] src_height;
        logic [STEP_W-1:0] x_step;
        logic [STEP_W-1:0] y_step;
    } t_cfg;

    // One lane operand pair: result = a * 2^FRAC_BITS + d * f
    typedef struct packed {
        logic [LANE_A_W-1:0]        a;
        logic signed [LANE_D_W-1:0] d;
    } t_lane_req;

endpackage

FILE: sv/bilinear_image_scaler.sv
// ---------------------------------------------------------------------------
// bilinear_image_scaler: RGB frame store with bilinear resampling
// A write request stores one source pixel; busy stays low. A compute
// request keeps busy high, and the pixel appears on
// o_red_out/o_green_out/o_blue_out with o_valid for one cycle, in the
// cycle busy drops; no new request is accepted while busy is high. The
// busy period is set by the four reads from the single-port frame
// store and by the three-lane interpolation unit, used once for the source
// position, twice for the horizontal blends and once for the vertical
// blend. The result is shown for one cycle only and cannot be stalled.
// ---------------------------------------------------------------------------
module bilinear_image_scaler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_opcode,
    input  logic [bis_pkg::COORD_W-1:0]     i_col,
    input  logic [bis_pkg::COORD_W-1:0]     i_row,
    input  logic [bis_pkg::PIX_W-1:0]       i_red_in,
    input  logic [bis_pkg::PIX_W-1:0]       i_green_in,
    input  logic [bis_pkg::PIX_W-1:0]       i_blue_in,
    // result channel
    output logic                            o_valid,
    output logic [bis_pkg::PIX_W-1:0]       o_red_out,
    output logic [bis_pkg::PIX_W-1:0]       o_green_out,
    output logic [bis_pkg::PIX_W-1:0]       o_blue_out,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bis_pkg::PADDR_W-1:0]     paddr,
    input  logic [bis_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bis_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import bis_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_POS   = 4'd1;
    localparam logic [3:0] S_CLAMP = 4'd2;
    localparam logic [3:0] S_RDA   = 4'd3;
    localparam logic [3:0] S_RDB   = 4'd4;
    localparam logic [3:0] S_RDC   = 4'd5;
    localparam logic [3:0] S_RDD   = 4'd6;
    localparam logic [3:0] S_LRPB  = 4'd7;
    localparam logic [3:0] S_VERT  = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    t_cfg cfg;

    logic [3:0]             r_state;
    logic [3:0]             n_state;
    logic [COORD_W-1:0]     r_col;
    logic [COORD_W-1:0]     r_row;
    logic [COL_W-1:0]       r_x0;
    logic [COL_W-1:0]       r_x1;
    logic [ROW_W-1:0]       r_y0;
    logic [ROW_W-1:0]       r_y1;
    logic [FRAC_BITS-1:0]   r_fx;
    logic [FRAC_BITS-1:0]   r_fy;
    logic [RGB_W-1:0]       r_pa;
    logic [RGB_W-1:0]       r_pc;
    logic [LANES-1:0][LANE_A_W-1:0] r_top;
    logic                   r_valid;
    logic [PIX_W-1:0]       r_red;
    logic [PIX_W-1:0]       r_green;
    logic [PIX_W-1:0]       r_blue;

    logic                   accept;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_addr;
    logic [RGB_W-1:0]       mem_rdata;

    t_lane_req [LANES-1:0]  lane_req;
    logic [LANES-1:0][LANE_F_W-1:0] lane_frac;
    logic [LANES-1:0][LANE_O_W-1:0] lane_res;

    logic [COL_W-1:0]       wm1;
    logic [ROW_W-1:0]       hm1;
    logic [IX_W-1:0]        ix;
    logic [IX_W-1:0]        iy;
    logic [COL_W-1:0]       x0_c;
    logic [ROW_W-1:0]       y0_c;

    // Configuration registers
    bis_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Request handshake
    assign busy   = (r_state != S_IDLE);
    assign accept = start & ~busy;

    // Frame store port: writes in idle, neighbor reads during compute
    assign mem_we = accept && (i_opcode == OP_WRITE) &&
                    (i_col < COORD_W'(MAX_WIDTH)) && (i_row < COORD_W'(MAX_HEIGHT));

    always_comb begin
        case (r_state)
            S_RDA:   mem_addr = {r_x0, r_y0};
            S_RDB:   mem_addr = {r_x1, r_y0};
            S_RDC:   mem_addr = {r_x0, r_y1};
            S_RDD:   mem_addr = {r_x1, r_y1};
            default: mem_addr = {i_col[COL_W-1:0], i_row[ROW_W-1:0]};
        endcase
    end

    bis_frame_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata ({i_red_in, i_green_in, i_blue_in}),
        .o_rdata (mem_rdata)
    );

    // Last valid column and row after saturating the source size
    always_comb begin
        if (32'(cfg.src_width) > 32'(MAX_WIDTH)) begin
            wm1 = COL_W'(MAX_WIDTH - 1);
        end else if (cfg.src_width < SIZE_W'(2)) begin
            wm1 = COL_W'(1);
        end else begin
            wm1 = COL_W'(cfg.src_width - SIZE_W'(1));
        end
        if (32'(cfg.src_height) > 32'(MAX_HEIGHT)) begin
            hm1 = ROW_W'(MAX_HEIGHT - 1);
        end else if (cfg.src_height < SIZE_W'(2)) begin
            hm1 = ROW_W'(1);
        end else begin
            hm1 = ROW_W'(cfg.src_height - SIZE_W'(1));
        end
    end

    // Integer part of the position, clamped to the source edge
    assign ix   = lane_res[0][LANE_O_W-1:FRAC_BITS];
    assign iy   = lane_res[1][LANE_O_W-1:FRAC_BITS];
    assign x0_c = (ix >= IX_W'(wm1)) ? wm1 : ix[COL_W-1:0];
    assign y0_c = (iy >= IX_W'(hm1)) ? hm1 : iy[ROW_W-1:0];

    // Operand select for the shared interpolation unit
    always_comb begin
        logic signed [PIX_W:0]    dpix;
        logic signed [LANE_A_W:0] dtop;
        dpix = '0;
        dtop = '0;
        lane_req  = '0;
        lane_frac = '0;
        case (r_state)
            S_POS: begin
                // x on lane 0 scaled by the column, y on lane 1 by the row
                lane_req[0].d = $signed(LANE_D_W'(cfg.x_step));
                lane_req[1].d = $signed(LANE_D_W'(cfg.y_step));
                lane_frac[0]  = LANE_F_W'(r_col);
                lane_frac[1]  = LANE_F_W'(r_row);
            end
            S_RDC: begin
                // top blend: pa .. pb (pb on the read port)
                lane_frac = {LANES{LANE_F_W'(r_fx)}};
                for (int i = 0; i < LANES; i++) begin
                    dpix = $signed({1'b0, mem_rdata[(LANES-1-i)*PIX_W +: PIX_W]}) -
                           $signed({1'b0, r_pa[(LANES-1-i)*PIX_W +: PIX_W]});
                    lane_req[i].a = LANE_A_W'(r_pa[(LANES-1-i)*PIX_W +: PIX_W]);
                    lane_req[i].d = {{(LANE_D_W-PIX_W-1){dpix[PIX_W]}}, dpix};
                end
            end
            S_LRPB: begin
                // bottom blend: pc .. pd (pd on the read port)
                lane_frac = {LANES{LANE_F_W'(r_fx)}};
                for (int i = 0; i < LANES; i++) begin
                    dpix = $signed({1'b0, mem_rdata[(LANES-1-i)*PIX_W +: PIX_W]}) -
                           $signed({1'b0, r_pc[(LANES-1-i)*PIX_W +: PIX_W]});
                    lane_req[i].a = LANE_A_W'(r_pc[(LANES-1-i)*PIX_W +: PIX_W]);
                    lane_req[i].d = {{(LANE_D_W-PIX_W-1){dpix[PIX_W]}}, dpix};
                end
            end
            S_VERT: begin
                // vertical blend: top .. bottom (bottom in the unit output)
                lane_frac = {LANES{LANE_F_W'(r_fy)}};
                for (int i = 0; i < LANES; i++) begin
                    dtop = $signed({1'b0, lane_res[i][LANE_A_W-1:0]}) -
                           $signed({1'b0, r_top[i]});
                    lane_req[i].a = r_top[i];
                    lane_req[i].d = LANE_D_W'(dtop);
                end
            end
            default: begin
                lane_req  = '0;
                lane_frac = '0;
            end
        endcase
    end

    bis_lerp_unit u_lerp (
        .i_clk  (i_clk),
        .i_req  (lane_req),
        .i_frac (lane_frac),
        .o_res  (lane_res)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  n_state = (accept && (i_opcode == OP_COMPUTE)) ? S_POS : S_IDLE;
            S_POS:   n_state = S_CLAMP;
            S_CLAMP: n_state = S_RDA;
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_RDC;
            S_RDC:   n_state = S_RDD;
            S_RDD:   n_state = S_LRPB;
            S_LRPB:  n_state = S_VERT;
            S_VERT:  n_state = S_EMIT;
            S_EMIT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_EMIT);
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col <= i_col;
            r_row <= i_row;
        end
        if (r_state == S_CLAMP) begin
            r_x0 <= x0_c;
            r_x1 <= (x0_c == wm1) ? wm1 : x0_c + COL_W'(1);
            r_y0 <= y0_c;
            r_y1 <= (y0_c == hm1) ? hm1 : y0_c + ROW_W'(1);
            r_fx <= lane_res[0][FRAC_BITS-1:0];
            r_fy <= lane_res[1][FRAC_BITS-1:0];
        end
        if (r_state == S_RDB) begin
            r_pa <= mem_rdata;
        end
        if (r_state == S_RDD) begin
            r_pc <= mem_rdata;
            for (int i = 0; i < LANES; i++) begin
                r_top[i] <= lane_res[i][LANE_A_W-1:0];
            end
        end
        if (r_state == S_EMIT) begin
            r_red   <= lane_res[0][2*FRAC_BITS +: PIX_W];
            r_green <= lane_res[1][2*FRAC_BITS +: PIX_W];
            r_blue  <= lane_res[2][2*FRAC_BITS +: PIX_W];
        end
    end

    assign o_valid     = r_valid;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;

    // Checks
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_valid_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_EMIT))
        else $error("result strobe without a finished compute");

    a_compute_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == OP_COMPUTE)) |=> (r_state == S_POS))
        else $error("compute request did not start the sequencer");

    a_neighbor_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDA) |->
            ((r_x1 == r_x0) || (r_x1 == r_x0 + COL_W'(1))) &&
            ((r_y1 == r_y0) || (r_y1 == r_y0 + ROW_W'(1))))
        else $error("neighbor coordinates not adjacent");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !mem_we)
        else $error("frame store write during compute");

endmodule

FILE: sv/bis_lerp_unit.sv
// ---------------------------------------------------------------------------
// bis_lerp_unit: shared three-lane interpolation unit
// Each lane forms a * 2^FRAC_BITS + d * f with one signed multiplier and
// its own fraction f, and registers the result. Used for the source
// position, the horizontal and the vertical interpolation passes.
// ---------------------------------------------------------------------------
module bis_lerp_unit (
    input  logic                                           i_clk,
    input  bis_pkg::t_lane_req [bis_pkg::LANES-1:0]        i_req,
    input  logic [bis_pkg::LANES-1:0][bis_pkg::LANE_F_W-1:0] i_frac,
    output logic [bis_pkg::LANES-1:0][bis_pkg::LANE_O_W-1:0] o_res
);
    import bis_pkg::*;

    logic [LANES-1:0][LANE_O_W-1:0] n_res;
    logic [LANES-1:0][LANE_O_W-1:0] r_res;

    // Multiply-add per lane
    always_comb begin
        logic signed [LANE_P_W-1:0] prod;
        logic signed [LANE_P_W-1:0] base;
        logic signed [LANE_P_W-1:0] sum;
        for (int i = 0; i < LANES; i++) begin
            prod = LANE_P_W'($signed(i_req[i].d) * $signed({1'b0, i_frac[i]}));
            base = $signed(LANE_P_W'({i_req[i].a, {FRAC_BITS{1'b0}}}));
            sum  = base + prod;
            n_res[i] = sum[LANE_O_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

FILE: sv/bis_frame_store.sv
// ---------------------------------------------------------------------------
// bis_frame_store: single-port RGB frame store
// One access per cycle, a write also reads the old word; registered read.
// ---------------------------------------------------------------------------
module bis_frame_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [bis_pkg::ADDR_W-1:0]  i_addr,
    input  logic [bis_pkg::RGB_W-1:0]   i_wdata,
    output logic [bis_pkg::RGB_W-1:0]   o_rdata
);
    import bis_pkg::*;

    logic [RGB_W-1:0] r_mem [0:(1 << ADDR_W)-1];
    logic [RGB_W-1:0] r_rdata;

    // Shared port: write when enabled; the addressed word is always read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/bis_cfg_regs.sv
// ---------------------------------------------------------------------------
// bis_cfg_regs: APB configuration registers
// Source size and step registers, written with zero wait states.
// ---------------------------------------------------------------------------
module bis_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bis_pkg::PADDR_W-1:0]     paddr,
    input  logic [bis_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bis_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output bis_pkg::t_cfg                   o_cfg
);
    import bis_pkg::*;

    t_cfg                 r_cfg;
    t_cfg                 n_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[REG_IDX_W+1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // Write decode
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_SRC_WIDTH:  n_cfg.src_width  = pwdata[SIZE_W-1:0];
                REG_SRC_HEIGHT: n_cfg.src_height = pwdata[SIZE_W-1:0];
                REG_X_STEP:     n_cfg.x_step     = pwdata[STEP_W-1:0];
                REG_Y_STEP:     n_cfg.y_step     = pwdata[STEP_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width  <= RST_SRC_WIDTH;
            r_cfg.src_height <= RST_SRC_HEIGHT;
            r_cfg.x_step     <= RST_STEP;
            r_cfg.y_step     <= RST_STEP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_SRC_WIDTH:  prdata = APB_DATA_W'(r_cfg.src_width);
            REG_SRC_HEIGHT: prdata = APB_DATA_W'(r_cfg.src_height);
            REG_X_STEP:     prdata = APB_DATA_W'(r_cfg.x_step);
            REG_Y_STEP:     prdata = APB_DATA_W'(r_cfg.y_step);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
